FILE: sv/mas_pkg.sv
// ----------------------------------------------------------------------------
// mas_pkg: shared types and constants
// Sizes, operation codes, sequencer states and the structs passed along the
// multiply-accumulate cell chain.
// ----------------------------------------------------------------------------
package mas_pkg;

   // matrix dimension of the stores
   localparam int DIM = 16;
   // lanes in the cell chain: one per result column, field width caps it at 16
   localparam int LANES = (DIM < 16) ? DIM : 16;
   localparam int LANE_W = $clog2(LANES);
   localparam int A_DEPTH = 1 << (2 * LANE_W);

   // field widths
   localparam int FUNC_W = 2;
   localparam int IDX_W = 4;
   localparam int VAL_W = 16;
   localparam int SIZE_W = 5;
   localparam int SUM_W = 17;
   localparam int PROD_W = 32;
   localparam int ACC_W = 36;

   // effective size and sequencer counter widths
   localparam int N_W = $clog2(LANES + 1);
   localparam int CNT_W = $clog2(LANES + 4);
   localparam int DRAIN_EXTRA = 3;

   localparam logic [SIZE_W-1:0] SIZE_RESET = SIZE_W'(16);

   typedef enum logic [FUNC_W-1:0] {
      FUNC_LOAD_A = 2'd0,
      FUNC_LOAD_B = 2'd1,
      FUNC_ROW    = 2'd2
   } func_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_RUN,
      ST_DRAIN,
      ST_SHIFT
   } state_type;

   // element of row A traveling down the chain with its inner index
   typedef struct packed {
      logic                    valid;
      logic [LANE_W-1:0]       k;
      logic signed [VAL_W-1:0] a;
   } token_type;

   // per-cell control from the sequencer
   typedef struct packed {
      logic clear;
      logic shift;
   } cell_ctl_type;

   // write into one cell's column of B
   typedef struct packed {
      logic                    en;
      logic [LANE_W-1:0]       addr;
      logic signed [VAL_W-1:0] data;
   } bwr_type;

   // per-cell result, shifted toward cell 0 for unloading
   typedef struct packed {
      logic signed [VAL_W-1:0] a_cap;
      logic signed [VAL_W-1:0] b_cap;
      logic signed [ACC_W-1:0] acc;
   } cell_res_type;

endpackage

FILE: sv/mas_channels.sv
// ----------------------------------------------------------------------------
// mas channels: valid/ready channel interfaces
// Request, response and register write channels of the matrix unit.
// ----------------------------------------------------------------------------
interface mas_req_if
   import mas_pkg::*;
   ();
   logic                    valid;
   logic                    ready;
   logic [FUNC_W-1:0]       func;
   logic [IDX_W-1:0]        row_index;
   logic [IDX_W-1:0]        col_index;
   logic signed [VAL_W-1:0] element_value;

   modport source (output valid, func, row_index, col_index, element_value,
                   input ready);
   modport sink (input valid, func, row_index, col_index, element_value,
                 output ready);
endinterface

interface mas_rsp_if
   import mas_pkg::*;
   ();
   logic                    valid;
   logic                    ready;
   logic [IDX_W-1:0]        out_row;
   logic [IDX_W-1:0]        out_col;
   logic signed [SUM_W-1:0] sum_value;
   logic signed [SUM_W-1:0] diff_value;
   logic signed [ACC_W-1:0] product_value;
   logic                    last_of_row;

   modport source (output valid, out_row, out_col, sum_value, diff_value,
                   product_value, last_of_row, input ready);
   modport sink (input valid, out_row, out_col, sum_value, diff_value,
                 product_value, last_of_row, output ready);
endinterface

interface mas_csr_if
   import mas_pkg::*;
   ();
   logic              valid;
   logic              ready;
   logic [SIZE_W-1:0] data;

   modport source (output valid, data, input ready);
   modport sink (input valid, data, output ready);
endinterface

FILE: sv/mas_cell.sv
// ----------------------------------------------------------------------------
// mas_cell: one column lane of the multiply-accumulate chain
// Holds one column of B, multiplies passing A elements into an accumulator,
// captures A and B at its own cell and shifts results toward lane 0.
// ----------------------------------------------------------------------------
module mas_cell
   import mas_pkg::*;
(
   input  logic              clock,
   input  logic              reset,
   input  logic [LANE_W-1:0] col_id,
   input  logic [LANE_W-1:0] row,
   input  cell_ctl_type      ctl,
   input  bwr_type           bwr,
   input  token_type         tok_i,
   output token_type         tok_o,
   input  cell_res_type      res_i,
   output cell_res_type      res_o
);

   // column c of B, indexed by row k
   logic signed [VAL_W-1:0] col_mem [LANES];

   token_type               tok_ff;
   logic signed [VAL_W-1:0] b_ff;
   logic signed [PROD_W-1:0] prod_ff;
   logic                    pv_ff;
   cell_res_type            res_ff;
   cell_res_type            res_in;

   // column store: one write, one registered read
   always_ff @(posedge clock) begin
      if (bwr.en) begin
         col_mem[bwr.addr] <= bwr.data;
      end
      b_ff <= col_mem[tok_i.k];
   end

   // token stage and multiplier stage
   always_ff @(posedge clock) begin
      if (reset) begin
         tok_ff.valid <= 1'b0;
         pv_ff        <= 1'b0;
      end else begin
         tok_ff.valid <= tok_i.valid;
         pv_ff        <= tok_ff.valid;
      end
      tok_ff.k <= tok_i.k;
      tok_ff.a <= tok_i.a;
      prod_ff  <= PROD_W'(tok_ff.a) * PROD_W'(b_ff);
   end

   // clear or accumulate, capture own cell, or shift from the right neighbor
   always_comb begin
      res_in = res_ff;
      if (ctl.shift) begin
         res_in = res_i;
      end else begin
         if (ctl.clear) begin
            res_in.acc = '0;
         end else if (pv_ff) begin
            res_in.acc = res_ff.acc + ACC_W'(prod_ff);
         end
         if (tok_ff.valid && tok_ff.k == col_id) begin
            res_in.a_cap = tok_ff.a;
         end
         if (tok_ff.valid && tok_ff.k == row) begin
            res_in.b_cap = b_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      res_ff <= res_in;
   end

   assign tok_o = tok_ff;
   assign res_o = res_ff;

endmodule

FILE: sv/matrix_add_sub_multiply.sv
// ----------------------------------------------------------------------------
// matrix_add_sub_multiply: matrix add, subtract and multiply unit
// Square matrices A and B are loaded one element per transfer; a row request
// returns sums, differences and inner products for every column of the row.
// ----------------------------------------------------------------------------
// Usage:
//   req_ch: func 0/1 loads element (row_index, col_index) of A/B, func 2
//   requests one result row. A load returns nothing.
//   rsp_ch: n transfers per in-range row request, n = min(active_size, 16),
//   columns in ascending order, last_of_row on the final one.
//   csr_ch: always ready; writes active_size. Write only while idle.
// Timing: a row request streams row r of A through a chain of n column cells,
//   one element per cycle, with a three-stage read/multiply/accumulate path
//   per cell; the chain then unloads one column per cycle through lane 0,
//   unless the response stalls. Without stalls, the time from request to
//   last transfer is set by the issue of n A elements, the chain latency
//   and the unload. Requests are taken only while the sequencer is idle, so
//   a new row waits for the last to unload; out-of-range rows end with no result.
// Reset: control clears and active_size returns to 16; stored elements are
//   undefined until written. A stalled response holds the unload in place.
// ----------------------------------------------------------------------------
module matrix_add_sub_multiply
   import mas_pkg::*;
(
   input  logic   clock,
   input  logic   reset,
   mas_req_if.sink   req_ch,
   mas_rsp_if.source rsp_ch,
   mas_csr_if.sink   csr_ch
);

   logic [SIZE_W-1:0] active_size_ff;
   state_type         state_ff, state_in;
   logic [CNT_W-1:0]  cnt_ff, cnt_in;
   logic [N_W-1:0]    n_ff;
   logic [LANE_W-1:0] row_ff;

   logic signed [VAL_W-1:0] store_a [A_DEPTH];
   logic signed [VAL_W-1:0] a_rd_ff;
   logic                    tok_v_ff;
   logic [LANE_W-1:0]       tok_k_ff;

   logic              req_xfer;
   logic              load_ok;
   logic              row_ok;
   logic              start;
   logic              issue;
   logic              out_free;
   logic [N_W-1:0]    eff_size;
   logic [CNT_W-1:0]  n_last;
   cell_ctl_type      ctl;

   token_type    tok_link [LANES+1];
   cell_res_type res_link [LANES+1];

   logic                    rsp_v_ff;
   logic [IDX_W-1:0]        rsp_row_ff;
   logic [IDX_W-1:0]        rsp_col_ff;
   logic signed [SUM_W-1:0] rsp_sum_ff;
   logic signed [SUM_W-1:0] rsp_diff_ff;
   logic signed [ACC_W-1:0] rsp_prod_ff;
   logic                    rsp_last_ff;

   // size register
   assign csr_ch.ready = 1'b1;
   always_ff @(posedge clock) begin
      if (reset) begin
         active_size_ff <= SIZE_RESET;
      end else if (csr_ch.valid) begin
         active_size_ff <= csr_ch.data;
      end
   end

   // request decode
   assign eff_size = (active_size_ff > SIZE_W'(LANES)) ? N_W'(LANES)
                                                      : N_W'(active_size_ff);
   assign req_ch.ready = (state_ff == ST_IDLE);
   assign req_xfer = req_ch.valid && req_ch.ready;
   assign load_ok = (SIZE_W'(req_ch.row_index) < SIZE_W'(LANES)) &&
                    (SIZE_W'(req_ch.col_index) < SIZE_W'(LANES));
   assign row_ok = SIZE_W'(req_ch.row_index) < SIZE_W'(eff_size);
   assign start = req_xfer && (req_ch.func == FUNC_ROW) && row_ok;
   assign n_last = CNT_W'(n_ff) - CNT_W'(1);
   assign out_free = !rsp_v_ff || rsp_ch.ready;

   // sequencer: issue row of A, drain the chain, unload columns
   always_comb begin
      state_in  = state_ff;
      cnt_in    = cnt_ff;
      issue     = 1'b0;
      ctl.clear = 1'b0;
      ctl.shift = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            if (start) begin
               state_in  = ST_RUN;
               cnt_in    = '0;
               ctl.clear = 1'b1;
            end
         end
         ST_RUN: begin
            issue = 1'b1;
            if (cnt_ff == n_last) begin
               state_in = ST_DRAIN;
               cnt_in   = '0;
            end else begin
               cnt_in = cnt_ff + CNT_W'(1);
            end
         end
         ST_DRAIN: begin
            if (cnt_ff == CNT_W'(n_ff) + CNT_W'(DRAIN_EXTRA)) begin
               state_in = ST_SHIFT;
               cnt_in   = '0;
            end else begin
               cnt_in = cnt_ff + CNT_W'(1);
            end
         end
         ST_SHIFT: begin
            if (out_free) begin
               ctl.shift = 1'b1;
               if (cnt_ff == n_last) begin
                  state_in = ST_IDLE;
                  cnt_in   = '0;
               end else begin
                  cnt_in = cnt_ff + CNT_W'(1);
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
            cnt_in   = '0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         cnt_ff   <= '0;
         tok_v_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         cnt_ff   <= cnt_in;
         tok_v_ff <= issue;
      end
   end

   // row and size of the request in flight
   always_ff @(posedge clock) begin
      if (start) begin
         row_ff <= req_ch.row_index[LANE_W-1:0];
         n_ff   <= eff_size;
      end
   end

   // store of A: load port and row read feeding lane 0
   always_ff @(posedge clock) begin
      if (req_xfer && req_ch.func == FUNC_LOAD_A && load_ok) begin
         store_a[{req_ch.row_index[LANE_W-1:0], req_ch.col_index[LANE_W-1:0]}]
            <= req_ch.element_value;
      end
      a_rd_ff  <= store_a[{row_ff, cnt_ff[LANE_W-1:0]}];
      tok_k_ff <= cnt_ff[LANE_W-1:0];
   end

   assign tok_link[0].valid = tok_v_ff;
   assign tok_link[0].k     = tok_k_ff;
   assign tok_link[0].a     = a_rd_ff;
   assign res_link[LANES]   = '0;

   // chain of column cells
   for (genvar c = 0; c < LANES; c++) begin : g_cell
      bwr_type   bwr;
      token_type tok_in;
      assign bwr.en = req_xfer && (req_ch.func == FUNC_LOAD_B) && load_ok &&
                      (req_ch.col_index[LANE_W-1:0] == LANE_W'(c));
      assign bwr.addr = req_ch.row_index[LANE_W-1:0];
      assign bwr.data = req_ch.element_value;

      // tokens stop at the last lane in use, so none linger past the row
      always_comb begin
         tok_in       = tok_link[c];
         tok_in.valid = tok_link[c].valid && (N_W'(c) < n_ff);
      end

      mas_cell u_cell (
         .clock  (clock),
         .reset  (reset),
         .col_id (LANE_W'(c)),
         .row    (row_ff),
         .ctl    (ctl),
         .bwr    (bwr),
         .tok_i  (tok_in),
         .tok_o  (tok_link[c+1]),
         .res_i  (res_link[c+1]),
         .res_o  (res_link[c])
      );
   end

   // response register, loaded from lane 0 on each shift
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_v_ff <= 1'b0;
      end else if (ctl.shift) begin
         rsp_v_ff <= 1'b1;
      end else if (rsp_ch.ready) begin
         rsp_v_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (ctl.shift) begin
         rsp_row_ff  <= IDX_W'(row_ff);
         rsp_col_ff  <= IDX_W'(cnt_ff);
         rsp_sum_ff  <= {res_link[0].a_cap[VAL_W-1], res_link[0].a_cap} +
                        {res_link[0].b_cap[VAL_W-1], res_link[0].b_cap};
         rsp_diff_ff <= {res_link[0].a_cap[VAL_W-1], res_link[0].a_cap} -
                        {res_link[0].b_cap[VAL_W-1], res_link[0].b_cap};
         rsp_prod_ff <= res_link[0].acc;
         rsp_last_ff <= (cnt_ff == n_last);
      end
   end

   assign rsp_ch.valid         = rsp_v_ff;
   assign rsp_ch.out_row       = rsp_row_ff;
   assign rsp_ch.out_col       = rsp_col_ff;
   assign rsp_ch.sum_value     = rsp_sum_ff;
   assign rsp_ch.diff_value    = rsp_diff_ff;
   assign rsp_ch.product_value = rsp_prod_ff;
   assign rsp_ch.last_of_row   = rsp_last_ff;

`ifndef ASSERT_OFF
   // an in-range row request always starts issuing
   a_start_run: assert property (@(posedge clock) disable iff (reset)
      start |=> state_ff == ST_RUN)
      else $error("row request did not start issue");

   // the last-of-row flag marks the final column of the active size
   a_last_col: assert property (@(posedge clock) disable iff (reset)
      ctl.shift |=> (rsp_last_ff == (CNT_W'(rsp_col_ff) == n_last)))
      else $error("last_of_row on wrong column");

   // no token is fed into the chain while it is unloaded
   a_drained: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_SHIFT |-> !tok_v_ff)
      else $error("token still in flight during unload");

   // no shift while the response register holds a stalled transfer
   a_no_overrun: assert property (@(posedge clock) disable iff (reset)
      (rsp_v_ff && !rsp_ch.ready) |-> !ctl.shift)
      else $error("response overwritten while stalled");
`endif

endmodule
